// ===== rtl/core/fdpc_pkg.sv =====
package fdpc_pkg;

  localparam int unsigned TimeW  = 29;
  localparam int unsigned TrackW = 8;
  localparam int unsigned ElapW  = 24;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [TrackW-1:0] TrackLimit = 8'd158;
  localparam logic [TrackW-1:0] TrackMax   = 8'd255;

  localparam logic [TimeW-1:0] StepTimeRst  = 29'd12000;
  localparam logic [TimeW-1:0] EjectTimeRst = 29'd500000000;

  // register indexes
  localparam logic [CfgIdxW-1:0] RegStepTime  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegEjectTime = 2'd1;
  localparam logic [CfgIdxW-1:0] RegWrProt    = 2'd2;
  localparam logic [CfgIdxW-1:0] RegDblSided  = 2'd3;

  // control commands (strobe falling edge)
  localparam logic [3:0] CtlStepIn    = 4'h0;
  localparam logic [3:0] CtlStepOut   = 4'h1;
  localparam logic [3:0] CtlClrEject  = 4'h3;
  localparam logic [3:0] CtlStep      = 4'h4;
  localparam logic [3:0] CtlMotorOn   = 4'h8;
  localparam logic [3:0] CtlMotorOff  = 4'h9;
  localparam logic [3:0] CtlEject     = 4'hD;

  // queries (strobe low, no edge)
  localparam logic [3:0] QryStepDir   = 4'h0;
  localparam logic [3:0] QryLowerHead = 4'h1;
  localparam logic [3:0] QryNoDisk    = 4'h2;
  localparam logic [3:0] QryUpperHead = 4'h3;
  localparam logic [3:0] QryStepDone  = 4'h4;
  localparam logic [3:0] QryWrEnable  = 4'h6;
  localparam logic [3:0] QryMotorOff  = 4'h8;
  localparam logic [3:0] QryDblSided  = 4'h9;
  localparam logic [3:0] QryNotTrk0   = 4'hA;
  localparam logic [3:0] QryStepBusy  = 4'hB;
  localparam logic [3:0] QryNotEject  = 4'hC;

  typedef struct packed {
    logic [TimeW-1:0]  step_time;
    logic [TimeW-1:0]  eject_time;
    logic              wr_prot;
    logic              dbl_sided;
  } cfg_t;

  typedef struct packed {
    logic [TimeW-1:0]  timer;
    logic [TrackW-1:0] track;
    logic              step_inward;
    logic              upper_head;
    logic              ejected;
    logic              ejecting;
    logic              strobe_seen;
    logic              motor;
    logic              disk;
  } drv_state_t;

  typedef struct packed {
    logic [3:0]        phase;
    logic              head_select;
    logic [ElapW-1:0]  elapsed_ns;
    logic              drive_active;
    logic              insert_disk;
  } item_t;

endpackage

// ===== rtl/core/fdpc_update.sv =====
module fdpc_update (
  input  fdpc_pkg::cfg_t       cfg_i,
  input  fdpc_pkg::drv_state_t state_i,
  input  fdpc_pkg::item_t      item_i,
  output fdpc_pkg::drv_state_t state_o,
  output logic                 sense_o
);
  import fdpc_pkg::*;

  logic [3:0]        cmd;
  logic [TimeW-1:0]  elap_ext;
  logic              expired;
  drv_state_t        s;
  logic              sense;

  assign cmd      = {item_i.phase[1], item_i.phase[0], item_i.head_select, item_i.phase[2]};
  assign elap_ext = {{(TimeW-ElapW){1'b0}}, item_i.elapsed_ns};

  always_comb begin
    s       = state_i;
    sense   = 1'b0;
    expired = 1'b0;
    if (item_i.drive_active) begin
      if (item_i.insert_disk) begin
        s.disk = 1'b1;
      end
      // timer saturates at zero
      s.timer = (state_i.timer > elap_ext) ? (state_i.timer - elap_ext) : '0;
      expired = (state_i.timer != '0) && (s.timer == '0);
      if (expired) begin
        if (state_i.ejecting) begin
          s.ejecting = 1'b0;
          s.ejected  = 1'b1;
          s.disk     = 1'b0;
        end else if (state_i.step_inward) begin
          if (state_i.track < TrackLimit) begin
            s.track = state_i.track + 8'd2;
          end
        end else if (state_i.track >= 8'd2) begin
          s.track = state_i.track - 8'd2;
        end
      end

      if (item_i.phase[3]) begin
        s.strobe_seen = 1'b1;
      end else if (state_i.strobe_seen) begin
        s.strobe_seen = 1'b0;
        case (cmd)
          CtlStepIn:   s.step_inward = 1'b1;
          CtlStepOut:  s.step_inward = 1'b0;
          CtlClrEject: s.ejected = 1'b0;
          CtlStep: begin
            if (!s.ejecting) begin
              s.timer = cfg_i.step_time;
            end
          end
          CtlMotorOn:  s.motor = 1'b1;
          CtlMotorOff: s.motor = 1'b0;
          CtlEject: begin
            if (!s.ejecting) begin
              s.motor    = 1'b0;
              s.ejecting = 1'b1;
              s.timer    = cfg_i.eject_time;
            end
          end
          default: ;
        endcase
      end else begin
        case (cmd)
          QryStepDir:   sense = !s.step_inward;
          QryLowerHead: begin
            if (s.upper_head) begin
              if (s.track != '0) begin
                s.track = s.track - 8'd1;
              end
              s.upper_head = 1'b0;
            end
          end
          QryNoDisk:    sense = !s.disk;
          QryUpperHead: begin
            if (!s.upper_head) begin
              if (s.track != TrackMax) begin
                s.track = s.track + 8'd1;
              end
              s.upper_head = 1'b1;
            end
          end
          QryStepDone:  sense = (s.timer == '0);
          QryWrEnable:  sense = s.disk & !cfg_i.wr_prot;
          QryMotorOff:  sense = !s.motor;
          QryDblSided:  sense = s.disk & cfg_i.dbl_sided;
          QryNotTrk0:   sense = (state_i.track != '0);
          QryStepBusy:  sense = (s.timer != '0);
          QryNotEject:  sense = !s.ejected;
          default:      sense = 1'b0;
        endcase
      end
    end
  end

  assign state_o = s;
  assign sense_o = sense;

endmodule

// ===== rtl/core/floppy_drive_phase_command_unit.sv =====
// phase command unit of a 3.5 inch floppy drive
// input channel (in_valid_i / in_ready_o): one transfer per sampled set of
//   phase lines, head select, elapsed time, drive select and insert event
// output channel (out_valid_o / out_ready_i): one result transfer per input
//   transfer, carrying sense, quarter track, spindle, disk and eject status
// config port: cfg_we_i writes register cfg_idx_i (0 step time, 1 eject
//   time, 2 write protect, 3 double sided) with cfg_data_i, no wait
// order: an input transfer lands in the input register; when the result register
//   is free or being emptied, the drive state is updated and the result register
//   loads, and the result becomes visible
// throughput: one item per cycle while results are taken; the state update is
//   one short pass of logic from input register into state and result registers
// stall: when the receiver holds out_ready_i low the result register keeps
//   its value, the input register still takes one more transfer if empty, and then
//   in_ready_o drops until the result is taken
// reset: drive state cleared (track 0, motor off, no disk, timer idle),
//   config registers back to their defaults, both channels empty
module floppy_drive_phase_command_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [fdpc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [fdpc_pkg::TimeW-1:0]    cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [3:0]                    phase_i,
  input  logic                          head_select_i,
  input  logic [fdpc_pkg::ElapW-1:0]    elapsed_ns_i,
  input  logic                          drive_active_i,
  input  logic                          insert_disk_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          sense_o,
  output logic [fdpc_pkg::TrackW-1:0]   quarter_track_o,
  output logic                          spindle_on_o,
  output logic                          disk_loaded_o,
  output logic                          eject_busy_o
);
  import fdpc_pkg::*;

  cfg_t       cfg_q;
  drv_state_t state_q, state_d;
  item_t      item_q;
  logic       in_valid_q;
  logic       out_valid_q;
  logic       sense_d, sense_q;
  logic       advance;
  logic       in_xfer;

  // item moves from the input register into state/result when the result
  // register is free or being emptied this cycle
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;
  assign in_xfer    = in_valid_i && in_ready_o;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.step_time  <= StepTimeRst;
      cfg_q.eject_time <= EjectTimeRst;
      cfg_q.wr_prot    <= 1'b0;
      cfg_q.dbl_sided  <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegStepTime:  cfg_q.step_time  <= cfg_data_i;
        RegEjectTime: cfg_q.eject_time <= cfg_data_i;
        RegWrProt:    cfg_q.wr_prot    <= cfg_data_i[0];
        RegDblSided:  cfg_q.dbl_sided  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      item_q.phase        <= phase_i;
      item_q.head_select  <= head_select_i;
      item_q.elapsed_ns   <= elapsed_ns_i;
      item_q.drive_active <= drive_active_i;
      item_q.insert_disk  <= insert_disk_i;
    end
  end

  fdpc_update u_update (
    .cfg_i   (cfg_q),
    .state_i (state_q),
    .item_i  (item_q),
    .state_o (state_d),
    .sense_o (sense_d)
  );

  // drive state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // result register; status outputs read straight from the state, which
  // only changes together with the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      sense_q <= sense_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign sense_o         = sense_q;
  assign quarter_track_o = state_q.track;
  assign spindle_on_o    = state_q.motor;
  assign disk_loaded_o   = state_q.disk;
  assign eject_busy_o    = state_q.ejecting;

  // an accepted item always shows up in the input register
  a_in_capture: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> in_valid_q)
    else $error("accepted item not held in input register");

  // every state update produces a pending result
  a_adv_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_o)
    else $error("state advanced without a result");

  // starting an eject always stops the motor
  a_eject_motor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(state_q.ejecting) |-> !state_q.motor)
    else $error("eject started with motor running");

  // a finished eject leaves no disk behind
  a_eject_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(state_q.ejecting) |-> !state_q.disk)
    else $error("eject finished but disk still present");

endmodule
